@@ sv/pcs_pkg.sv @@
// ----------------------------------------------------------------------------
// Peer choke scheduler package
// Shared widths, codes, controller states and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int PeerCount = 16;
  localparam int IdxW      = 4;
  localparam int RatingW   = 32;
  localparam int SlotW     = 5;
  localparam int RndW      = 16;
  localparam int OpW       = 3;
  localparam int RndBitW   = 4;

  localparam logic [SlotW-1:0] SlotsReset = 5'd4;

  typedef logic [OpW-1:0] op_t;

  localparam op_t OpSetRating     = 3'd0;
  localparam op_t OpInterested    = 3'd1;
  localparam op_t OpNotInterested = 3'd2;
  localparam op_t OpUnregister    = 3'd3;
  localparam op_t OpFullRound     = 3'd4;

  localparam logic ActUnchoke = 1'b0;
  localparam logic ActChoke   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PART,
    ST_RK_NEXT,
    ST_RK_CAP,
    ST_RK_CMP,
    ST_DIV_INIT,
    ST_DIV,
    ST_PICK,
    ST_PREP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic load;
    logic part;
    logic rk_start;
    logic rk_cap;
    logic rk_cmp;
    logic div_init;
    logic div_step;
    logic pick_step;
    logic prep;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic op_full;
    logic full_trivial;
    logic need_partial;
    logic part_go;
    logic todo_empty;
    logic rk_last;
    logic div_done;
    logic pick_done;
    logic msgs_none;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

@@ sv/peer_choke_scheduler.sv @@
// ----------------------------------------------------------------------------
// Peer choke scheduler
// Upload slot scheduler: keeps a peer table and emits choke and unchoke words.
// ----------------------------------------------------------------------------
// Events enter on the in channel (valid/ready) and are handled one at a time.
// Each resulting choke or unchoke message leaves on the out channel as one
// word, with last set on the final word of an event; events that cause no
// message give no word. The slot count is written through upload_slots_we_i;
// the user must write it only while the block is idle, as the block itself
// does not enforce this. A round ranks each peer in its candidate set against
// the other members of that set, one rating memory read per cycle. A full
// round with more interested peers than a nonzero slot count then reduces the
// random pick modulo the candidate count and makes the optimistic pick.
// Words then leave at one per cycle while the receiver takes them.
// A stalled receiver holds the current word in the output register and the
// scheduler waits; the next event is taken once the last word is loaded.
// Reset clears all ratings and interest, chokes every peer and sets the slot
// count to four.
module peer_choke_scheduler import pcs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OpW-1:0]     op_i,
  input  logic [IdxW-1:0]    peer_index_i,
  input  logic [RatingW-1:0] rating_value_i,
  input  logic [RndW-1:0]    random_pick_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [IdxW-1:0]    target_peer_o,
  output logic               action_o,
  output logic               last_o,
  input  logic               upload_slots_we_i,
  input  logic [SlotW-1:0]   upload_slots_i
);

  cmd_t cmd;
  sts_t sts;

  pcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcs_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (op_i),
    .peer_index_i      (peer_index_i),
    .rating_value_i    (rating_value_i),
    .random_pick_i     (random_pick_i),
    .upload_slots_we_i (upload_slots_we_i),
    .upload_slots_i    (upload_slots_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .target_peer_o     (target_peer_o),
    .action_o          (action_o),
    .last_o            (last_o),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule

@@ sv/pcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// Peer choke scheduler controller
// Sequences event handling, ranking passes, the optimistic pick and the
// emission of choke and unchoke words.
// ----------------------------------------------------------------------------
module pcs_ctrl import pcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        if (sts_i.op_full) begin
          state_d = sts_i.full_trivial ? ST_PREP : ST_RK_NEXT;
        end else if (sts_i.need_partial) begin
          state_d = ST_PART;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PART: begin
        if (sts_i.part_go) begin
          cmd_o.part = 1'b1;
          state_d    = ST_RK_NEXT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RK_NEXT: begin
        if (sts_i.todo_empty) begin
          state_d = sts_i.op_full ? ST_DIV_INIT : ST_PREP;
        end else begin
          cmd_o.rk_start = 1'b1;
          state_d        = ST_RK_CAP;
        end
      end
      ST_RK_CAP: begin
        cmd_o.rk_cap = 1'b1;
        state_d      = ST_RK_CMP;
      end
      ST_RK_CMP: begin
        cmd_o.rk_cmp = 1'b1;
        if (sts_i.rk_last) begin
          state_d = ST_RK_NEXT;
        end
      end
      ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        cmd_o.pick_step = 1'b1;
        if (sts_i.pick_done) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = sts_i.msgs_none ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/pcs_dp.sv @@
// ----------------------------------------------------------------------------
// Peer choke scheduler datapath
// Peer table, rating memory, rank comparator, modulo unit, optimistic pick
// and the output word register.
// ----------------------------------------------------------------------------
module pcs_dp import pcs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [OpW-1:0]       op_i,
  input  logic [IdxW-1:0]      peer_index_i,
  input  logic [RatingW-1:0]   rating_value_i,
  input  logic [RndW-1:0]      random_pick_i,
  input  logic                 upload_slots_we_i,
  input  logic [SlotW-1:0]     upload_slots_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [IdxW-1:0]      target_peer_o,
  output logic                 action_o,
  output logic                 last_o,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o
);

  function automatic logic [SlotW-1:0] popcnt(input logic [PeerCount-1:0] v);
    logic [SlotW-1:0] c;
    c = '0;
    for (int i = 0; i < PeerCount; i++) begin
      c = c + {{(SlotW-1){1'b0}}, v[i]};
    end
    return c;
  endfunction

  function automatic logic [IdxW-1:0] lowest(input logic [PeerCount-1:0] v);
    logic [IdxW-1:0] r;
    r = '0;
    for (int i = PeerCount - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = IdxW'(i);
      end
    end
    return r;
  endfunction

  logic [RatingW-1:0]   rating_mem [PeerCount];
  logic [PeerCount-1:0] rating_vld_q;
  logic [PeerCount-1:0] interested_q, choked_q;
  logic [SlotW-1:0]     count_q, slots_q;
  op_t                  op_q;
  logic [IdxW-1:0]      idx_q;
  logic [RatingW-1:0]   rating_q;
  logic [RndW-1:0]      rnd_q;
  logic [PeerCount-1:0] set_q, todo_q, sel_q, cm_q, unch_q, chk_q;
  logic [SlotW-1:0]     k_q, cnt_q, rank_q, rem_q, d_q;
  logic [IdxW-1:0]      p_q, jr_q;
  logic [SlotW-1:0]     j_q;
  logic [RatingW-1:0]   pr_q, rd_q;
  logic [RndBitW-1:0]   dbit_q;
  logic                 out_valid_q;
  logic [IdxW-1:0]      target_q;
  logic                 action_q, last_q;

  logic [IdxW-1:0]      rd_addr, p_next, pick_low, emit_idx;
  logic                 mem_we;
  logic [RatingW-1:0]   mem_wdata;
  logic [SlotW-1:0]     cnt_all, m_cand, free_slots, k_part, nch, rank_nx;
  logic [PeerCount-1:0] cand, rest, rest_ch, unch_nx, chk_nx, unch_rem, chk_rem;
  logic                 beat, rk_last, emit_unch;
  logic [SlotW:0]       r6;

  assign cnt_all    = popcnt(interested_q);
  assign cand       = interested_q & choked_q;
  assign m_cand     = popcnt(cand);
  assign free_slots = slots_q - count_q;
  assign k_part     = (free_slots < m_cand) ? free_slots : m_cand;
  assign p_next     = lowest(todo_q);
  assign rd_addr    = cmd_i.rk_start ? p_next : j_q[IdxW-1:0];
  assign mem_we     = cmd_i.load &&
                      (op_q == OpSetRating || op_q == OpUnregister);
  assign mem_wdata  = (op_q == OpSetRating) ? rating_q : '0;

  assign beat = set_q[jr_q] && (jr_q != p_q) &&
                ((rd_q < pr_q) || ((rd_q == pr_q) && (jr_q < p_q)));
  assign rank_nx = rank_q + {{(SlotW-1){1'b0}}, beat};
  assign rk_last = (j_q == SlotW'(PeerCount));

  assign rest    = interested_q & ~sel_q;
  assign rest_ch = rest & choked_q;
  assign nch     = popcnt(rest_ch);
  assign r6      = {rem_q, rnd_q[dbit_q]};
  assign pick_low = lowest(cm_q);

  assign unch_nx = interested_q & sel_q & choked_q;
  assign chk_nx  = (op_q == OpFullRound) ? (interested_q & ~sel_q & ~choked_q) : '0;

  assign emit_unch = (unch_q != '0);
  assign emit_idx  = emit_unch ? lowest(unch_q) : lowest(chk_q);
  always_comb begin
    unch_rem = unch_q;
    chk_rem  = chk_q;
    if (emit_unch) begin
      unch_rem[emit_idx] = 1'b0;
    end else begin
      chk_rem[emit_idx] = 1'b0;
    end
  end

  always_comb begin
    sts_o              = '0;
    sts_o.op_full      = (op_q == OpFullRound);
    sts_o.full_trivial = (cnt_all <= slots_q) || (slots_q == '0);
    sts_o.need_partial = (op_q == OpInterested) ||
                         (((op_q == OpNotInterested) || (op_q == OpUnregister)) &&
                          !choked_q[idx_q]);
    sts_o.part_go      = (count_q < slots_q) && (m_cand != '0);
    sts_o.todo_empty   = (todo_q == '0);
    sts_o.rk_last      = rk_last;
    sts_o.div_done     = (dbit_q == '0);
    sts_o.pick_done    = (rem_q == '0);
    sts_o.msgs_none    = (unch_nx == '0) && (chk_nx == '0);
    sts_o.emit_last    = (unch_rem == '0) && (chk_rem == '0);
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rating_mem[idx_q] <= mem_wdata;
    end
    rd_q <= rating_vld_q[rd_addr] ? rating_mem[rd_addr] : '0;
    jr_q <= rd_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rating_vld_q <= '0;
      interested_q <= '0;
      choked_q     <= '1;
      count_q      <= '0;
      slots_q      <= SlotsReset;
      out_valid_q  <= 1'b0;
    end else begin
      if (upload_slots_we_i) begin
        slots_q <= upload_slots_i;
      end
      if (mem_we) begin
        rating_vld_q[idx_q] <= 1'b1;
      end
      if (cmd_i.load) begin
        case (op_q)
          OpInterested: begin
            interested_q[idx_q] <= 1'b1;
          end
          OpNotInterested: begin
            interested_q[idx_q] <= 1'b0;
            if (!choked_q[idx_q] && count_q != '0) begin
              count_q <= count_q - 5'd1;
            end
          end
          OpUnregister: begin
            interested_q[idx_q] <= 1'b0;
            if (!choked_q[idx_q]) begin
              choked_q[idx_q] <= 1'b1;
              if (count_q != '0) begin
                count_q <= count_q - 5'd1;
              end
            end
          end
          OpFullRound: begin
            count_q <= (cnt_all < slots_q) ? cnt_all : slots_q;
          end
          default: begin
          end
        endcase
      end
      if (cmd_i.part) begin
        count_q <= count_q + k_part;
      end
      if (cmd_i.emit) begin
        choked_q[emit_idx] <= !emit_unch;
        out_valid_q        <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= op_i;
      idx_q    <= peer_index_i;
      rating_q <= rating_value_i;
      rnd_q    <= random_pick_i;
    end
    if (cmd_i.load && op_q == OpFullRound) begin
      cnt_q  <= cnt_all;
      set_q  <= interested_q;
      todo_q <= sts_o.full_trivial ? '0 : interested_q;
      sel_q  <= (cnt_all <= slots_q) ? interested_q : '0;
      k_q    <= slots_q - 5'd1;
    end
    if (cmd_i.part) begin
      set_q  <= cand;
      todo_q <= cand;
      sel_q  <= '0;
      k_q    <= k_part;
    end
    if (cmd_i.rk_start) begin
      p_q            <= p_next;
      todo_q[p_next] <= 1'b0;
      j_q            <= '0;
      rank_q         <= '0;
    end
    if (cmd_i.rk_cap) begin
      pr_q <= rd_q;
      j_q  <= j_q + 5'd1;
    end
    if (cmd_i.rk_cmp) begin
      j_q    <= j_q + 5'd1;
      rank_q <= rank_nx;
      if (rk_last) begin
        sel_q[p_q] <= (rank_nx < k_q);
      end
    end
    if (cmd_i.div_init) begin
      cm_q   <= (nch != '0) ? rest_ch : rest;
      d_q    <= (nch != '0) ? nch : (cnt_q - k_q);
      rem_q  <= '0;
      dbit_q <= RndBitW'(RndW - 1);
    end
    if (cmd_i.div_step) begin
      rem_q  <= (r6 >= {1'b0, d_q}) ? SlotW'(r6 - {1'b0, d_q}) : r6[SlotW-1:0];
      dbit_q <= dbit_q - 4'd1;
    end
    if (cmd_i.pick_step) begin
      if (rem_q == '0) begin
        sel_q[pick_low] <= 1'b1;
      end else begin
        cm_q[pick_low] <= 1'b0;
        rem_q          <= rem_q - 5'd1;
      end
    end
    if (cmd_i.prep) begin
      unch_q <= unch_nx;
      chk_q  <= chk_nx;
    end
    if (cmd_i.emit) begin
      unch_q   <= unch_rem;
      chk_q    <= chk_rem;
      target_q <= emit_idx;
      action_q <= emit_unch ? ActUnchoke : ActChoke;
      last_q   <= sts_o.emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign target_peer_o = target_q;
  assign action_o      = action_q;
  assign last_o        = last_q;

endmodule

@@ sim/peer_choke_scheduler_test.sv @@
// ----------------------------------------------------------------------------
// Peer choke scheduler testbench
// Drives peer events through the scheduler at several slot counts and checks
// every choke and unchoke word against a predictor of the peer table.
// ----------------------------------------------------------------------------
module peer_choke_scheduler_test;
  import pcs_pkg::*;

  localparam op_t OpSpareFirst = 3'd5;
  localparam op_t OpSpareLast  = 3'd7;
  localparam int  SettleCycles = 400;

  typedef struct {
    logic [IdxW-1:0] peer;
    logic            act;
    logic            last;
  } choke_word_t;

  class choke_board;
    logic [RatingW-1:0] rating [PeerCount];
    logic [PeerCount-1:0] interested;
    logic [PeerCount-1:0] choked;
    int unsigned count;
    int unsigned slots;
    choke_word_t pending [$];
    int errors;

    function new();
      foreach (rating[i]) rating[i] = '0;
      interested = '0;
      choked = '1;
      count = 0;
      slots = SlotsReset;
      errors = 0;
    endfunction

    function void add_word(int p, logic a);
      choke_word_t w;
      w.peer = p[IdxW-1:0];
      w.act = a;
      w.last = 1'b0;
      pending.push_back(w);
    endfunction

    function bit beats(int a, int b);
      return rating[a] < rating[b] || (rating[a] == rating[b] && a < b);
    endfunction

    function int rank_among(logic [PeerCount-1:0] set, int p);
      int r;
      r = 0;
      for (int j = 0; j < PeerCount; j++)
        if (set[j] && j != p && beats(j, p)) r++;
      return r;
    endfunction

    function void fill_slots();
      logic [PeerCount-1:0] cand;
      int m;
      int k;
      if (count >= slots) return;
      cand = interested & choked;
      m = $countones(cand);
      if (m == 0) return;
      k = slots - count;
      if (k > m) k = m;
      for (int i = 0; i < PeerCount; i++)
        if (cand[i] && rank_among(cand, i) < k) begin
          choked[i] = 1'b0;
          add_word(i, ActUnchoke);
        end
      count += k;
    endfunction

    function void run_round(logic [RndW-1:0] rnd);
      logic [PeerCount-1:0] sel;
      logic [PeerCount-1:0] rest;
      int cnt;
      int best;
      int nchoked;
      int ncand;
      int pick;
      bit only_choked;
      sel = '0;
      rest = '0;
      cnt = $countones(interested);
      if (cnt <= slots) begin
        sel = interested;
      end else if (slots >= 1) begin
        best = slots - 1;
        nchoked = 0;
        for (int i = 0; i < PeerCount; i++) begin
          if (!interested[i]) continue;
          if (rank_among(interested, i) < best) begin
            sel[i] = 1'b1;
          end else begin
            rest[i] = 1'b1;
            if (choked[i]) nchoked++;
          end
        end
        only_choked = nchoked > 0;
        ncand = only_choked ? nchoked : cnt - best;
        pick = int'(rnd) % ncand;
        for (int i = 0; i < PeerCount; i++) begin
          if (!rest[i] || (only_choked && !choked[i])) continue;
          if (pick == 0) begin
            sel[i] = 1'b1;
            break;
          end
          pick--;
        end
      end
      for (int i = 0; i < PeerCount; i++)
        if (interested[i] && sel[i] && choked[i]) begin
          choked[i] = 1'b0;
          add_word(i, ActUnchoke);
        end
      for (int i = 0; i < PeerCount; i++)
        if (interested[i] && !sel[i] && !choked[i]) begin
          choked[i] = 1'b1;
          add_word(i, ActChoke);
        end
      count = cnt < slots ? cnt : slots;
    endfunction

    function void note_event(op_t op, logic [IdxW-1:0] p, logic [RatingW-1:0] rt,
                             logic [RndW-1:0] rnd);
      int before_n;
      before_n = pending.size();
      case (op)
        OpFullRound: run_round(rnd);
        OpSetRating: rating[p] = rt;
        OpInterested: begin
          interested[p] = 1'b1;
          fill_slots();
        end
        OpNotInterested: begin
          interested[p] = 1'b0;
          if (!choked[p]) begin
            if (count > 0) count--;
            fill_slots();
          end
        end
        OpUnregister: begin
          interested[p] = 1'b0;
          rating[p] = '0;
          if (!choked[p]) begin
            if (count > 0) count--;
            choked[p] = 1'b1;
            fill_slots();
          end
        end
        default: ;
      endcase
      if (pending.size() > before_n) pending[pending.size()-1].last = 1'b1;
    endfunction

    function void check_word(logic [IdxW-1:0] p, logic a, logic l);
      choke_word_t w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected word: peer %0d action %0d last %0d", p, a, l);
        return;
      end
      w = pending.pop_front();
      if (w.peer !== p || w.act !== a || w.last !== l) begin
        errors++;
        if (errors <= 10)
          $display("Word mismatch: expected peer %0d action %0d last %0d, got %0d %0d %0d",
                   w.peer, w.act, w.last, p, a, l);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  op_t                op_i;
  logic [IdxW-1:0]    peer_index_i;
  logic [RatingW-1:0] rating_value_i;
  logic [RndW-1:0]    random_pick_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [IdxW-1:0]    target_peer_o;
  logic               action_o;
  logic               last_o;
  logic               upload_slots_we_i;
  logic [SlotW-1:0]   upload_slots_i;

  choke_board board;
  int burst_left;
  int rx_mode;
  int rx_left;
  logic [7:0] rx_pattern;

  peer_choke_scheduler uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .peer_index_i,
    .rating_value_i, .random_pick_i, .out_valid_o, .out_ready_i, .target_peer_o,
    .action_o, .last_o, .upload_slots_we_i, .upload_slots_i
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_word(target_peer_o, action_o, last_o);

  initial begin
    out_ready_i = 1'b0;
    rx_mode = 0;
    rx_left = 0;
    rx_pattern = 8'hff;
    forever begin
      @(negedge clk_i);
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 96);
        rx_pattern = 8'($urandom);
      end
      rx_left--;
      rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= rx_pattern[0];
      endcase
    end
  end

  task automatic send_event(op_t op, logic [IdxW-1:0] p, logic [RatingW-1:0] rt,
                            logic [RndW-1:0] rnd);
    int gap;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    op_i = op;
    peer_index_i = p;
    rating_value_i = rt;
    random_pick_i = rnd;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_event(op, p, rt, rnd);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_slots(logic [SlotW-1:0] v);
    @(negedge clk_i);
    upload_slots_we_i = 1'b1;
    upload_slots_i = v;
    @(negedge clk_i);
    upload_slots_we_i = 1'b0;
    board.slots = v;
  endtask

  task automatic random_event();
    int pct;
    logic [RatingW-1:0] rt;
    logic [IdxW-1:0] p;
    logic [RatingW-1:0] rv;
    logic [RndW-1:0] rnd;
    pct = $urandom_range(0, 99);
    rt = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7);
    p = IdxW'($urandom);
    rv = $urandom;
    rnd = RndW'($urandom);
    if (pct < 25) send_event(OpSetRating, p, rt, rnd);
    else if (pct < 50) send_event(OpInterested, p, rv, rnd);
    else if (pct < 63) send_event(OpNotInterested, p, rv, rnd);
    else if (pct < 72) send_event(OpUnregister, p, rv, rnd);
    else if (pct < 95) send_event(OpFullRound, p, rv, rnd);
    else send_event(op_t'($urandom_range(OpSpareFirst, OpSpareLast)), p, rv, rnd);
  endtask

  initial begin
    logic [SlotW-1:0] settings [$];
    board = new();
    burst_left = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = OpSetRating;
    peer_index_i = '0;
    rating_value_i = '0;
    random_pick_i = '0;
    upload_slots_we_i = 1'b0;
    upload_slots_i = SlotsReset;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes of rating and pick, every op, ties and spare ops.
    send_event(OpSetRating, 4'd15, 32'hffffffff, 16'h0);
    send_event(OpSetRating, 4'd3, 32'h0, 16'hffff);
    send_event(OpSetRating, 4'd5, 32'h5, 16'h0);
    send_event(OpSetRating, 4'd6, 32'h5, 16'h0);
    for (int i = 0; i < PeerCount; i += 2)
      send_event(OpInterested, IdxW'(i), 32'h0, 16'h0);
    send_event(OpFullRound, 4'd0, 32'h0, 16'hffff);
    send_event(OpFullRound, 4'd0, 32'h0, 16'h0);
    send_event(OpInterested, 4'd5, 32'h0, 16'h0);
    send_event(OpInterested, 4'd15, 32'h0, 16'h0);
    send_event(OpNotInterested, 4'd0, 32'h0, 16'h0);
    send_event(OpUnregister, 4'd2, 32'h0, 16'h0);
    send_event(OpUnregister, 4'd13, 32'h0, 16'h0);
    send_event(OpSpareLast, 4'd1, 32'hffffffff, 16'hffff);
    send_event(OpSpareFirst, 4'd2, 32'h0, 16'h0);
    send_event(OpFullRound, 4'd15, 32'hffffffff, 16'h8001);
    drain();

    settings = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd4, 5'd8};
    settings.push_back(SlotW'($urandom_range(1, 16)));
    foreach (settings[s]) begin
      write_slots(settings[s]);
      for (int n = 0; n < 32; n++) random_event();
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
